>>> rtl/sleof_pkg.sv
// Shared types and constants for the start/length/end frame receiver.
// Holds the parse phase, status codes, configuration and result types.
// No dependencies.
`default_nettype none
package sleof_pkg;

  localparam int unsigned LenWidth  = 16;
  localparam int unsigned FlenWidth = 17;

  // Header (start, type, two length bytes) plus trailer (four CRC bytes, end).
  localparam logic [FlenWidth-1:0] HDR_TRL_BYTES = 17'd9;
  localparam logic [LenWidth-1:0]  CRC_BYTES     = 16'd4;

  localparam logic [7:0]           START_BYTE_RESET = 8'd170;
  localparam logic [7:0]           END_BYTE_RESET   = 8'd187;
  localparam logic [FlenWidth-1:0] MAX_LEN_RESET    = 17'd1033;

  typedef enum logic [1:0] {
    REG_START_BYTE = 2'd0,
    REG_END_BYTE   = 2'd1,
    REG_MAX_LENGTH = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    PH_WAIT  = 3'd0,
    PH_TYPE  = 3'd1,
    PH_LENLO = 3'd2,
    PH_LENHI = 3'd3,
    PH_DATA  = 3'd4,
    PH_CRC   = 3'd5,
    PH_END   = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_START = 3'd1,
    ST_BAD_END   = 3'd2,
    ST_LINK      = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0]           start_byte;
    logic [7:0]           end_byte;
    logic [FlenWidth-1:0] max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic                 kind;
    logic [7:0]           payload_byte;
    logic [LenWidth-1:0]  payload_index;
    logic [2:0]           status;
    logic [7:0]           frame_type;
    logic [LenWidth-1:0]  payload_length;
    logic [31:0]          crc_field;
    logic [FlenWidth-1:0] frame_length;
  } result_t;

endpackage
`default_nettype wire

>>> rtl/sleof_step.sv
// Frame parser state and per-byte update for the frame receiver.
// Depends on sleof_pkg for the phase, status, configuration and result types.
`default_nettype none
module sleof_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              step_en,
  input  logic [7:0]        rx_byte,
  input  logic              rx_error,
  input  sleof_pkg::cfg_t   cfg,
  output sleof_pkg::result_t res,
  output logic              res_valid
);
  import sleof_pkg::*;

  phase_t               phase, phase_next;
  logic [LenWidth-1:0]  byte_count, byte_count_next;
  logic [LenWidth-1:0]  length_seen, length_seen_next;
  logic [7:0]           type_seen, type_seen_next;
  logic [31:0]          crc_seen, crc_seen_next;
  logic                 oversize, oversize_next;

  logic                 do_end;
  status_t              end_status;
  logic [FlenWidth-1:0] end_flen;
  logic [LenWidth-1:0]  cnt_inc;
  logic [LenWidth-1:0]  len_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_WAIT;
      byte_count  <= '0;
      length_seen <= '0;
      type_seen   <= '0;
      crc_seen    <= '0;
      oversize    <= 1'b0;
    end else if (step_en) begin
      phase       <= phase_next;
      byte_count  <= byte_count_next;
      length_seen <= length_seen_next;
      type_seen   <= type_seen_next;
      crc_seen    <= crc_seen_next;
      oversize    <= oversize_next;
    end
  end

  always_comb begin
    phase_next       = phase;
    byte_count_next  = byte_count;
    length_seen_next = length_seen;
    type_seen_next   = type_seen;
    crc_seen_next    = crc_seen;
    oversize_next    = oversize;
    do_end           = 1'b0;
    end_status       = ST_OK;
    end_flen         = '0;
    res_valid        = 1'b0;
    res              = '0;
    res.frame_type     = type_seen;
    res.payload_length = length_seen;
    cnt_inc          = byte_count + 16'd1;
    len_full         = {rx_byte, length_seen[7:0]};

    if (rx_error) begin
      do_end     = 1'b1;
      end_status = ST_LINK;
    end else begin
      unique case (phase)
        PH_WAIT: begin
          if (rx_byte != cfg.start_byte) begin
            do_end     = 1'b1;
            end_status = ST_BAD_START;
          end else begin
            phase_next = PH_TYPE;
          end
        end
        PH_TYPE: begin
          type_seen_next = rx_byte;
          phase_next     = PH_LENLO;
        end
        PH_LENLO: begin
          length_seen_next = {8'd0, rx_byte};
          phase_next       = PH_LENHI;
        end
        PH_LENHI: begin
          length_seen_next = len_full;
          oversize_next    = ({1'b0, len_full} + HDR_TRL_BYTES) > cfg.max_frame_length;
          byte_count_next  = '0;
          phase_next       = (len_full == '0) ? PH_CRC : PH_DATA;
        end
        PH_DATA: begin
          if (cnt_inc >= length_seen) begin
            byte_count_next = '0;
            phase_next      = PH_CRC;
          end else begin
            byte_count_next = cnt_inc;
          end
          if (!oversize) begin
            res_valid         = 1'b1;
            res.kind          = 1'b0;
            res.payload_byte  = rx_byte;
            res.payload_index = byte_count;
          end
        end
        PH_CRC: begin
          crc_seen_next = crc_seen | ({24'd0, rx_byte} << {byte_count[1:0], 3'b000});
          if (cnt_inc >= CRC_BYTES) begin
            byte_count_next = '0;
            phase_next      = PH_END;
          end else begin
            byte_count_next = cnt_inc;
          end
        end
        PH_END: begin
          do_end = 1'b1;
          if (rx_byte != cfg.end_byte) begin
            end_status = ST_BAD_END;
          end else if (oversize) begin
            end_status = ST_TOO_LONG;
          end else begin
            end_status = ST_OK;
            end_flen   = {1'b0, length_seen} + HDR_TRL_BYTES;
          end
        end
        default: begin
          phase_next       = PH_WAIT;
          byte_count_next  = '0;
          length_seen_next = '0;
          type_seen_next   = '0;
          crc_seen_next    = '0;
          oversize_next    = 1'b0;
        end
      endcase
    end

    if (do_end) begin
      res_valid        = 1'b1;
      res.kind         = 1'b1;
      res.status       = end_status;
      res.crc_field    = crc_seen;
      res.frame_length = end_flen;
      phase_next       = PH_WAIT;
      byte_count_next  = '0;
      length_seen_next = '0;
      type_seen_next   = '0;
      crc_seen_next    = '0;
      oversize_next    = 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/sof_length_eof_frame_receiver_top.sv
// Top level of the start/length/end frame receiver.
// Depends on sleof_pkg and sleof_step.
`default_nettype none
// Usage:
// Received bytes enter on the input channel (in_valid/in_ready, rx_byte,
// rx_error), one item per byte. Frames are start byte, type byte, 16-bit
// little-endian payload length, payload bytes, four CRC bytes and an end byte.
// Each payload byte leaves as a kind 0 item; a completed or aborted frame
// leaves as one kind 1 item with status, type, length, raw CRC and length.
// Bytes that produce no result (header, CRC, oversize payload) leave nothing.
// The block takes one byte per cycle while the output side does not stall. An
// accepted byte is held in the input register and its result is then loaded
// into the result register, which drives out_valid.
// The parser state and the result register sit behind one short update step,
// so there is no bubble between bytes.
// When the output side stalls, bytes that make no result keep flowing; a byte
// that makes a result waits in the input register and in_ready drops only
// once that register is also occupied.
// Reset (rst, synchronous) empties both registers, returns the parser to
// waiting for a start byte and loads the default configuration: start byte
// 170, end byte 187, largest frame length 1033. Configuration is written on
// cfg_we with cfg_index and cfg_data by the user only while the block is idle;
// the block does not enforce it; an index beyond the register list is ignored.
module sof_length_eof_frame_receiver_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        rx_error,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        kind,
  output logic [7:0]  payload_byte,
  output logic [15:0] payload_index,
  output logic [2:0]  status,
  output logic [7:0]  frame_type,
  output logic [15:0] payload_length,
  output logic [31:0] crc_field,
  output logic [16:0] frame_length
);
  import sleof_pkg::*;

  cfg_t       cfg;
  logic       in_q_valid;
  logic [7:0] in_q_byte;
  logic       in_q_error;
  logic       advance;
  logic       in_take;
  result_t    step_res;
  logic       step_res_valid;
  result_t    out_q;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_byte       <= START_BYTE_RESET;
      cfg.end_byte         <= END_BYTE_RESET;
      cfg.max_frame_length <= MAX_LEN_RESET;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_START_BYTE: cfg.start_byte       <= cfg_data[7:0];
        REG_END_BYTE:   cfg.end_byte         <= cfg_data[7:0];
        REG_MAX_LENGTH: cfg.max_frame_length <= cfg_data;
        default: ;
      endcase
    end
  end

  // The held byte moves on when it makes no result or the result slot
  // is free or being emptied this cycle.
  assign advance  = in_q_valid && (!step_res_valid || !out_valid || out_ready);
  assign in_ready = !in_q_valid || advance;
  assign in_take  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_q_byte  <= rx_byte;
      in_q_error <= rx_error;
    end
  end

  sleof_step u_step (
    .clk       (clk),
    .rst       (rst),
    .step_en   (advance),
    .rx_byte   (in_q_byte),
    .rx_error  (in_q_error),
    .cfg       (cfg),
    .res       (step_res),
    .res_valid (step_res_valid)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && step_res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_res_valid) begin
      out_q <= step_res;
    end
  end

  assign kind           = out_q.kind;
  assign payload_byte   = out_q.payload_byte;
  assign payload_index  = out_q.payload_index;
  assign status         = out_q.status;
  assign frame_type     = out_q.frame_type;
  assign payload_length = out_q.payload_length;
  assign crc_field      = out_q.crc_field;
  assign frame_length   = out_q.frame_length;

endmodule
`default_nettype wire
